@@ design/cartesian_to_spherical_macros.svh @@
// Assertion macros for the cartesian to spherical converter.
// Used by the top level; expects signals named clock and reset in scope.
`ifndef CARTESIAN_TO_SPHERICAL_MACROS_SVH
`define CARTESIAN_TO_SPHERICAL_MACROS_SVH

// Same-cycle implication, off while reset is high
`define C2S_ASSERT_NOW(name, cond_a, cond_b, text) \
   name: assert property (@(posedge clock) disable iff (reset) (cond_a) |-> (cond_b)) \
      else $error(text);

// Next-cycle implication, off while reset is high
`define C2S_ASSERT_NEXT(name, cond_a, cond_b, text) \
   name: assert property (@(posedge clock) disable iff (reset) (cond_a) |=> (cond_b)) \
      else $error(text);

// Next-cycle implication that also holds across reset
`define C2S_ASSERT_ALWAYS(name, cond_a, cond_b, text) \
   name: assert property (@(posedge clock) (cond_a) |=> (cond_b)) \
      else $error(text);

`endif

@@ design/c2s_pkg.sv @@
// Shared constants, types and arithmetic steps of the cartesian to spherical converter.
// No dependencies; used by the channel interfaces and the top level.
package c2s_pkg;

   // Field widths
   localparam int CoordWidth    = 16;
   localparam int AngleWidth    = 16;
   localparam int CordicStages  = 16;

   // Internal formats: operands are scaled to RootWidth bits
   localparam int RootWidth     = 32;
   localparam int GuardBits     = RootWidth - CoordWidth;
   localparam int RadicandWidth = 2 * RootWidth;
   localparam int RemWidth      = RootWidth + 2;
   localparam int CordWidth     = RootWidth + 4;
   localparam int AngWidth      = 34;           // angle in units of pi/2^30
   localparam int FracShift     = 30 - (AngleWidth - 1);
   localparam int RoundHalf     = 2 ** (FracShift - 1);
   localparam int QuarterTurn   = 2 ** 29;
   localparam int MaxUnits      = 2 ** (AngleWidth - 1);

   // Pipeline layout
   localparam int SqrtFirst     = 2;
   localparam int PolStart      = SqrtFirst + RootWidth;
   localparam int PolFirst      = PolStart + 1;
   localparam int NumStages     = PolFirst + CordicStages;

   typedef struct packed {
      logic [RadicandWidth-1:0] rad;
      logic [RootWidth-1:0]     root;
      logic [RemWidth-1:0]      rem;
   } sqrt_type;

   typedef struct packed {
      logic signed [CordWidth-1:0] a;
      logic signed [CordWidth-1:0] b;
      logic signed [AngWidth-1:0]  ang;
   } cordic_type;

   // atan(2^-i)/pi * 2^30, rounded
   function automatic logic signed [AngWidth-1:0] atan_value(input int idx);
      case (idx)
         0:  atan_value = AngWidth'(268435456);
         1:  atan_value = AngWidth'(158466703);
         2:  atan_value = AngWidth'(83729454);
         3:  atan_value = AngWidth'(42502378);
         4:  atan_value = AngWidth'(21333666);
         5:  atan_value = AngWidth'(10677233);
         6:  atan_value = AngWidth'(5339919);
         7:  atan_value = AngWidth'(2670123);
         8:  atan_value = AngWidth'(1335082);
         9:  atan_value = AngWidth'(667543);
         10: atan_value = AngWidth'(333772);
         11: atan_value = AngWidth'(166886);
         12: atan_value = AngWidth'(83443);
         13: atan_value = AngWidth'(41722);
         14: atan_value = AngWidth'(20861);
         15: atan_value = AngWidth'(10430);
         16: atan_value = AngWidth'(5215);
         17: atan_value = AngWidth'(2608);
         18: atan_value = AngWidth'(1304);
         19: atan_value = AngWidth'(652);
         20: atan_value = AngWidth'(326);
         21: atan_value = AngWidth'(163);
         22: atan_value = AngWidth'(81);
         23: atan_value = AngWidth'(41);
         24: atan_value = AngWidth'(20);
         25: atan_value = AngWidth'(10);
         26: atan_value = AngWidth'(5);
         27: atan_value = AngWidth'(3);
         28: atan_value = AngWidth'(1);
         29: atan_value = AngWidth'(1);
         default: atan_value = '0;
      endcase
   endfunction

   // Component scaled to the CORDIC operand format
   function automatic logic signed [CordWidth-1:0] scale_coord(
      input logic signed [CoordWidth-1:0] c);
      scale_coord = CordWidth'(c) <<< GuardBits;
   endfunction

   // One digit of the restoring square root
   function automatic sqrt_type sqrt_step(input sqrt_type st);
      logic [RemWidth-1:0] rem2;
      logic [RemWidth-1:0] trial;
      sqrt_type            nx;
      rem2   = {st.rem[RootWidth-1:0], st.rad[RadicandWidth-1 -: 2]};
      trial  = {st.root, 2'b01};
      nx.rad = {st.rad[RadicandWidth-3:0], 2'b00};
      if (rem2 >= trial) begin
         nx.rem  = rem2 - trial;
         nx.root = {st.root[RootWidth-2:0], 1'b1};
      end else begin
         nx.rem  = rem2;
         nx.root = {st.root[RootWidth-2:0], 1'b0};
      end
      return nx;
   endfunction

   // Fold the left half plane onto the right one
   function automatic cordic_type cordic_prerotate(
      input logic signed [CordWidth-1:0] a,
      input logic signed [CordWidth-1:0] b);
      cordic_type nx;
      nx.a   = a;
      nx.b   = b;
      nx.ang = '0;
      if (a[CordWidth-1]) begin
         if (!b[CordWidth-1]) begin
            nx.a   = b;
            nx.b   = -a;
            nx.ang = AngWidth'(QuarterTurn);
         end else begin
            nx.a   = -b;
            nx.b   = a;
            nx.ang = -AngWidth'(QuarterTurn);
         end
      end
      return nx;
   endfunction

   // One vectoring micro-rotation
   function automatic cordic_type cordic_step(input cordic_type st, input int idx);
      logic signed [CordWidth-1:0] sa;
      logic signed [CordWidth-1:0] sb;
      cordic_type                  nx;
      sa = $signed(st.a) >>> idx;
      sb = $signed(st.b) >>> idx;
      if (!st.b[CordWidth-1]) begin
         nx.a   = $signed(st.a) + sb;
         nx.b   = $signed(st.b) - sa;
         nx.ang = $signed(st.ang) + atan_value(idx);
      end else begin
         nx.a   = $signed(st.a) - sb;
         nx.b   = $signed(st.b) + sa;
         nx.ang = $signed(st.ang) - atan_value(idx);
      end
      return nx;
   endfunction

endpackage

@@ design/c2s_req_if.sv @@
// Input channel of the cartesian to spherical converter: one vector per item.
// Depends on c2s_pkg.
interface c2s_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [c2s_pkg::CoordWidth-1:0] coord_x;
   logic signed [c2s_pkg::CoordWidth-1:0] coord_y;
   logic signed [c2s_pkg::CoordWidth-1:0] coord_z;

   modport source (output valid, output coord_x, output coord_y, output coord_z,
                   input ready);
   modport sink   (input valid, input coord_x, input coord_y, input coord_z,
                   output ready);
endinterface

@@ design/c2s_rsp_if.sv @@
// Result channel of the cartesian to spherical converter: one result per item.
// Depends on c2s_pkg.
interface c2s_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic        [c2s_pkg::CoordWidth-1:0] radius;
   logic        [c2s_pkg::AngleWidth-1:0] polar_angle;
   logic signed [c2s_pkg::AngleWidth-1:0] azimuth;
   logic                                 zero_vector;

   modport source (output valid, output radius, output polar_angle, output azimuth,
                   output zero_vector, input ready);
   modport sink   (input valid, input radius, input polar_angle, input azimuth,
                   input zero_vector, output ready);
endinterface

@@ design/cartesian_to_spherical.sv @@
// Cartesian to spherical converter. Takes one signed vector (x, y, z) per item and
// returns its rounded length, the polar angle from +z (0..32768) and the azimuth
// atan2(y, x) (-32768..32767), both in units of pi/32768; a zero vector returns zeros
// with zero_vector set. A new item is taken every cycle while the pipeline advances;
// each item passes through squares, sums, 32 square-root digit stages (which also carry
// the 16 azimuth CORDIC stages), a fold stage, 16 polar CORDIC stages and the output
// register. The whole pipeline advances together whenever the output register is
// empty or being read, so backpressure freezes it without loss.
// Depends on c2s_pkg, c2s_req_if, c2s_rsp_if and cartesian_to_spherical_macros.svh.
`include "cartesian_to_spherical_macros.svh"

module cartesian_to_spherical (
   input logic       clock,
   input logic       reset,
   c2s_req_if.sink   req_bus,
   c2s_rsp_if.source rsp_bus
);

   typedef struct packed {
      logic                                  zero;
      logic                                  axis;
      logic signed [c2s_pkg::CoordWidth-1:0] coord_z;
      logic [2*c2s_pkg::CoordWidth-1:0]      sq_x;
      logic [2*c2s_pkg::CoordWidth-1:0]      sq_y;
      logic [2*c2s_pkg::CoordWidth-1:0]      sq_z;
      c2s_pkg::sqrt_type                     rad;
      c2s_pkg::sqrt_type                     rho;
      c2s_pkg::cordic_type                   az;
      c2s_pkg::cordic_type                   pol;
   } stage_type;

   localparam int LastStage = c2s_pkg::NumStages - 1;

   stage_type                      stage_ff [c2s_pkg::NumStages];
   stage_type                      stage_in [c2s_pkg::NumStages];
   logic [c2s_pkg::NumStages-1:0]  valid_ff;
   logic [c2s_pkg::NumStages-1:0]  valid_in;
   logic                           advance;

   logic                                  out_valid_ff;
   logic [c2s_pkg::CoordWidth-1:0]        radius_ff;
   logic [c2s_pkg::CoordWidth-1:0]        radius_in;
   logic [c2s_pkg::AngleWidth-1:0]        polar_ff;
   logic [c2s_pkg::AngleWidth-1:0]        polar_in;
   logic signed [c2s_pkg::AngleWidth-1:0] azimuth_ff;
   logic signed [c2s_pkg::AngleWidth-1:0] azimuth_in;
   logic                                  zero_ff;
   logic                                  zero_in;

   // Whole pipeline moves when the output register is free or being drained
   assign advance       = !out_valid_ff || rsp_bus.ready;
   assign req_bus.ready = advance;
   assign valid_in      = {valid_ff[c2s_pkg::NumStages-2:0], req_bus.valid};

   // Stage 0: squares, flags and azimuth fold
   always_comb begin
      logic signed [2*c2s_pkg::CoordWidth-1:0] x_ext;
      logic signed [2*c2s_pkg::CoordWidth-1:0] y_ext;
      logic signed [2*c2s_pkg::CoordWidth-1:0] z_ext;
      x_ext = (2*c2s_pkg::CoordWidth)'(req_bus.coord_x);
      y_ext = (2*c2s_pkg::CoordWidth)'(req_bus.coord_y);
      z_ext = (2*c2s_pkg::CoordWidth)'(req_bus.coord_z);
      stage_in[0]         = '0;
      stage_in[0].sq_x    = $unsigned(x_ext * x_ext);
      stage_in[0].sq_y    = $unsigned(y_ext * y_ext);
      stage_in[0].sq_z    = $unsigned(z_ext * z_ext);
      stage_in[0].axis    = (req_bus.coord_x == '0) && (req_bus.coord_y == '0);
      stage_in[0].zero    = stage_in[0].axis && (req_bus.coord_z == '0);
      stage_in[0].coord_z = req_bus.coord_z;
      stage_in[0].az      = c2s_pkg::cordic_prerotate(
                               c2s_pkg::scale_coord(req_bus.coord_x),
                               c2s_pkg::scale_coord(req_bus.coord_y));
   end

   // Stage 1: sums of squares, loaded as radicands
   always_comb begin
      logic [2*c2s_pkg::CoordWidth-1:0] sum_all;
      logic [2*c2s_pkg::CoordWidth-1:0] sum_xy;
      sum_xy  = stage_ff[0].sq_x + stage_ff[0].sq_y;
      sum_all = sum_xy + stage_ff[0].sq_z;
      stage_in[1]          = stage_ff[0];
      stage_in[1].rad.rad  = c2s_pkg::RadicandWidth'(sum_all) << (2 * c2s_pkg::GuardBits);
      stage_in[1].rad.root = '0;
      stage_in[1].rad.rem  = '0;
      stage_in[1].rho.rad  = c2s_pkg::RadicandWidth'(sum_xy) << (2 * c2s_pkg::GuardBits);
      stage_in[1].rho.root = '0;
      stage_in[1].rho.rem  = '0;
   end

   // Square-root digit stages; radius and azimuth ride along in the early ones
   for (genvar k = 0; k < c2s_pkg::RootWidth; k++) begin : g_sqrt
      always_comb begin
         stage_in[c2s_pkg::SqrtFirst+k]     = stage_ff[c2s_pkg::SqrtFirst+k-1];
         stage_in[c2s_pkg::SqrtFirst+k].rho =
            c2s_pkg::sqrt_step(stage_ff[c2s_pkg::SqrtFirst+k-1].rho);
         if (k < c2s_pkg::CoordWidth) begin
            stage_in[c2s_pkg::SqrtFirst+k].rad =
               c2s_pkg::sqrt_step(stage_ff[c2s_pkg::SqrtFirst+k-1].rad);
         end
         if (k < c2s_pkg::CordicStages) begin
            stage_in[c2s_pkg::SqrtFirst+k].az =
               c2s_pkg::cordic_step(stage_ff[c2s_pkg::SqrtFirst+k-1].az, k);
         end
      end
   end

   // Fold stage for the polar angle: atan2(rho, z)
   always_comb begin
      stage_in[c2s_pkg::PolStart]     = stage_ff[c2s_pkg::PolStart-1];
      stage_in[c2s_pkg::PolStart].pol = c2s_pkg::cordic_prerotate(
         c2s_pkg::scale_coord(stage_ff[c2s_pkg::PolStart-1].coord_z),
         c2s_pkg::CordWidth'(stage_ff[c2s_pkg::PolStart-1].rho.root));
   end

   // Polar CORDIC stages
   for (genvar i = 0; i < c2s_pkg::CordicStages; i++) begin : g_polar
      always_comb begin
         stage_in[c2s_pkg::PolFirst+i]     = stage_ff[c2s_pkg::PolFirst+i-1];
         stage_in[c2s_pkg::PolFirst+i].pol =
            c2s_pkg::cordic_step(stage_ff[c2s_pkg::PolFirst+i-1].pol, i);
      end
   end

   // Output stage: rounding, angle units, saturation and special cases
   always_comb begin
      logic [c2s_pkg::CoordWidth-1:0]       root;
      logic signed [c2s_pkg::AngWidth-1:0]  az_units;
      logic signed [c2s_pkg::AngWidth-1:0]  pol_units;
      logic signed [c2s_pkg::AngWidth-1:0]  units_max;
      root      = stage_ff[LastStage].rad.root[c2s_pkg::CoordWidth-1:0];
      units_max = c2s_pkg::AngWidth'(c2s_pkg::MaxUnits);
      az_units  = ($signed(stage_ff[LastStage].az.ang)
                   + c2s_pkg::AngWidth'(c2s_pkg::RoundHalf)) >>> c2s_pkg::FracShift;
      pol_units = ($signed(stage_ff[LastStage].pol.ang)
                   + c2s_pkg::AngWidth'(c2s_pkg::RoundHalf)) >>> c2s_pkg::FracShift;

      if (stage_ff[LastStage].rad.rem > c2s_pkg::RemWidth'(root)) begin
         radius_in = root + 1'b1;
      end else begin
         radius_in = root;
      end

      // +pi wraps to -pi, anything below -pi pins there
      if ((az_units >= units_max) || (az_units < -units_max)) begin
         azimuth_in = c2s_pkg::AngleWidth'(c2s_pkg::MaxUnits);
      end else begin
         azimuth_in = az_units[c2s_pkg::AngleWidth-1:0];
      end

      if (pol_units < 0) begin
         polar_in = '0;
      end else if (pol_units > units_max) begin
         polar_in = c2s_pkg::AngleWidth'(c2s_pkg::MaxUnits);
      end else begin
         polar_in = pol_units[c2s_pkg::AngleWidth-1:0];
      end

      zero_in = 1'b0;
      // On the z axis: azimuth 0, polar angle from the sign of z
      if (stage_ff[LastStage].axis) begin
         azimuth_in = '0;
         polar_in   = stage_ff[LastStage].coord_z[c2s_pkg::CoordWidth-1]
                      ? c2s_pkg::AngleWidth'(c2s_pkg::MaxUnits) : '0;
      end
      if (stage_ff[LastStage].zero) begin
         radius_in  = '0;
         polar_in   = '0;
         azimuth_in = '0;
         zero_in    = 1'b1;
      end
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff     <= valid_in;
         out_valid_ff <= valid_ff[LastStage];
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff   <= stage_in;
         radius_ff  <= radius_in;
         polar_ff   <= polar_in;
         azimuth_ff <= azimuth_in;
         zero_ff    <= zero_in;
      end
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.radius      = radius_ff;
   assign rsp_bus.polar_angle = polar_ff;
   assign rsp_bus.azimuth     = azimuth_ff;
   assign rsp_bus.zero_vector = zero_ff;

   // Checks
   `C2S_ASSERT_NOW(a_zero_clean, out_valid_ff && zero_ff,
      (radius_ff == '0) && (polar_ff == '0) && (azimuth_ff == '0),
      "zero vector with non-zero result")
   `C2S_ASSERT_NOW(a_polar_range, out_valid_ff,
      polar_ff <= c2s_pkg::AngleWidth'(c2s_pkg::MaxUnits), "polar angle beyond pi")
   `C2S_ASSERT_NEXT(a_valid_travel, valid_ff[0] && advance, valid_ff[1],
      "item lost between first stages")
   `C2S_ASSERT_NEXT(a_freeze, !advance, $stable(valid_ff), "pipeline moved while stalled")
   `C2S_ASSERT_ALWAYS(a_reset_clear, reset, !out_valid_ff && (valid_ff == '0),
      "items survive reset")

endmodule

@@ dv/c2s_checker.sv @@
// Result checker for the cartesian to spherical converter: predicts each result
// from the accepted vector and compares it with the output. Depends on c2s_pkg
// and the c2s_req_if / c2s_rsp_if channel interfaces.
`timescale 1ns / 1ps

module c2s_checker (
   input logic       clock,
   input logic       reset,
   c2s_req_if.sink   req_mon,
   c2s_rsp_if.sink   rsp_mon,
   output int        fail_count,
   output int        pending_count,
   output int        result_count
);

   typedef struct packed {
      logic [c2s_pkg::CoordWidth-1:0]        radius;
      logic [c2s_pkg::AngleWidth-1:0]        polar_angle;
      logic signed [c2s_pkg::AngleWidth-1:0] azimuth;
      logic                                  zero_vector;
   } sph_result_type;

   sph_result_type expected_sph_q[$];
   longint         arctan_lut[32];

   // arctangent table in units of pi/2^30, from a power series in Q60
   initial begin
      longint rad, term;
      int     e;
      arctan_lut[0] = longint'(1) << 28;
      for (int i = 1; i < 32; i++) begin
         rad = 0;
         for (int k = 0; ; k++) begin
            e = 60 - (2 * k + 1) * i;
            if (e < 0) break;
            term = (longint'(1) << e) / (2 * k + 1);
            rad  = (k & 1) ? rad - term : rad + term;
         end
         rad = (rad + (longint'(1) << 27)) >>> 28;
         arctan_lut[i] = (rad * 64'sd1367130551 + (longint'(1) << 33)) >>> 34;
      end
   end

   function automatic longint int_sqrt(longint unsigned n);
      longint unsigned r, bit_v;
      r = 0;
      bit_v = 64'd1 << 62;
      while (bit_v > n) bit_v >>= 2;
      while (bit_v != 0) begin
         if (n >= r + bit_v) begin
            n -= r + bit_v;
            r = (r >> 1) + bit_v;
         end else begin
            r >>= 1;
         end
         bit_v >>= 2;
      end
      return longint'(r);
   endfunction

   // vectoring atan2(b, a) in units of pi/32768
   function automatic longint vector_angle(longint b, longint a);
      longint ang, t, na, nb;
      ang = 0;
      if (a < 0) begin
         if (b >= 0) begin
            t = a; a = b; b = -t; ang = longint'(1) << 29;
         end else begin
            t = a; a = -b; b = t; ang = -(longint'(1) << 29);
         end
      end
      for (int i = 0; i < c2s_pkg::CordicStages; i++) begin
         if (b >= 0) begin
            na = a + (b >>> i); nb = b - (a >>> i); ang += arctan_lut[i];
         end else begin
            na = a - (b >>> i); nb = b + (a >>> i); ang -= arctan_lut[i];
         end
         a = na; b = nb;
      end
      return (ang + (longint'(1) << 14)) >>> 15;
   endfunction

   function automatic sph_result_type convert_vector(longint x, longint y, longint z);
      sph_result_type  res;
      longint unsigned s;
      longint          r, rho, az, pol, sc;
      res = '0;
      if (x == 0 && y == 0 && z == 0) begin
         res.zero_vector = 1'b1;
         return res;
      end
      s = x * x + y * y + z * z;
      r = int_sqrt(s);
      res.radius = c2s_pkg::CoordWidth'((s - r * r > r) ? r + 1 : r);
      if (x == 0 && y == 0) begin
         az  = 0;
         pol = (z > 0) ? 0 : 32768;
      end else begin
         sc  = longint'(1) << c2s_pkg::GuardBits;
         rho = int_sqrt((x * x + y * y) << (2 * c2s_pkg::GuardBits));
         az  = vector_angle(y * sc, x * sc);
         if (az < -32768 || az >= 32768) az = -32768;
         pol = vector_angle(rho, z * sc);
         if (pol < 0) pol = 0;
         if (pol > 32768) pol = 32768;
      end
      res.polar_angle = c2s_pkg::AngleWidth'(pol);
      res.azimuth     = c2s_pkg::AngleWidth'(az);
      return res;
   endfunction

   // predict on input items, compare on result items
   always @(posedge clock) begin
      sph_result_type got, want;
      if (reset) begin
         expected_sph_q.delete();
      end else begin
         if (req_mon.valid && req_mon.ready)
            expected_sph_q.push_back(convert_vector(req_mon.coord_x, req_mon.coord_y,
                                                    req_mon.coord_z));
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{rsp_mon.radius, rsp_mon.polar_angle, rsp_mon.azimuth,
                    rsp_mon.zero_vector};
            result_count++;
            if (expected_sph_q.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result %p", $time, got);
            end else begin
               want = expected_sph_q.pop_front();
               if (got.radius !== want.radius ||
                   got.polar_angle !== want.polar_angle ||
                   got.azimuth !== want.azimuth ||
                   got.zero_vector !== want.zero_vector) begin
                  fail_count++;
                  $display("%0t: mismatch expected %p actual %p", $time, want, got);
               end
            end
         end
      end
      pending_count = expected_sph_q.size();
   end

   initial begin
      fail_count = 0;
      pending_count = 0;
      result_count = 0;
   end
endmodule

@@ dv/tb.sv @@
// Testbench top for the cartesian to spherical converter: clock, reset, vector
// stimulus and verdict. Depends on c2s_pkg, the channel interfaces and c2s_checker.
`timescale 1ns / 1ps

module tb;

   localparam int NumRandom = 1550;
   localparam int CycleLimit = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count, pending_count, result_count;
   int   cycle_count = 0;
   bit   steady_sink = 1'b0;
   int   sent_count = 0;

   c2s_req_if req_bus ();
   c2s_rsp_if rsp_bus ();

   cartesian_to_spherical u_top (.clock(clock), .reset(reset),
                                 .req_bus(req_bus), .rsp_bus(rsp_bus));

   c2s_checker u_checker (.clock(clock), .reset(reset), .req_mon(req_bus),
                          .rsp_mon(rsp_bus), .fail_count(fail_count),
                          .pending_count(pending_count), .result_count(result_count));

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // cycle limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // result side stalls at random, except during the steady stretch
   initial rsp_bus.ready = 1'b0;
   always @(posedge clock)
      rsp_bus.ready <= reset ? 1'b0 : (steady_sink || $urandom_range(99) >= 27);

   // present one vector, with a random gap first, and wait until taken;
   // valid stays up afterwards so the next item can follow without a gap
   task automatic send_vector(input logic [15:0] x, input logic [15:0] y,
                              input logic [15:0] z, input bit no_gap);
      if (!no_gap) begin
         while ($urandom_range(99) < 27) begin
            req_bus.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_bus.valid   <= 1'b1;
      req_bus.coord_x <= x;
      req_bus.coord_y <= y;
      req_bus.coord_z <= z;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sent_count++;
   endtask

   function automatic logic [15:0] pick_coord();
      case ($urandom_range(5))
         0: return 16'(16'sd0 + $signed(5'($urandom_range(31))) - 5'sd0);
         1: return 16'($urandom_range(3) == 0 ? 16'h8000 : 16'h7fff);
         2: return 16'($urandom_range(1) ? $urandom_range(8) : -$urandom_range(8));
         3: return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      logic [15:0] x, y, z;
      req_bus.valid   = 1'b0;
      req_bus.coord_x = '0;
      req_bus.coord_y = '0;
      req_bus.coord_z = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: zero vector, axes, extremes, octants, azimuth at pi
      send_vector(16'h0000, 16'h0000, 16'h0000, 1'b0);
      send_vector(16'h0000, 16'h0000, 16'h0001, 1'b0);
      send_vector(16'h0000, 16'h0000, 16'hffff, 1'b0);
      send_vector(16'h0000, 16'h0000, 16'h8000, 1'b0);
      send_vector(16'h0000, 16'h0000, 16'h7fff, 1'b0);
      send_vector(16'h8000, 16'h8000, 16'h8000, 1'b0);
      send_vector(16'h7fff, 16'h7fff, 16'h7fff, 1'b0);
      send_vector(16'h8000, 16'h0000, 16'h0000, 1'b0);
      send_vector(16'hffff, 16'h0000, 16'h0005, 1'b0);
      send_vector(16'h8000, 16'h0001, 16'h0000, 1'b0);
      send_vector(16'h8000, 16'hffff, 16'h0000, 1'b0);
      send_vector(16'h0001, 16'h0000, 16'h0000, 1'b0);
      send_vector(16'h0000, 16'h8000, 16'h0000, 1'b0);
      send_vector(16'h0000, 16'h7fff, 16'hffff, 1'b0);
      send_vector(16'h0003, 16'h0004, 16'h0000, 1'b0);
      send_vector(16'hfffd, 16'hfffc, 16'h000c, 1'b0);
      send_vector(16'h7fff, 16'h8000, 16'h0000, 1'b0);
      send_vector(16'h8000, 16'h7fff, 16'h8000, 1'b0);
      send_vector(16'h0001, 16'h0001, 16'h8000, 1'b0);
      send_vector(16'h5555, 16'haaaa, 16'h5555, 1'b0);
      send_vector(16'haaaa, 16'h5555, 16'haaaa, 1'b0);
      req_bus.valid <= 1'b0;
      @(posedge clock);

      // hold off until the pipeline has drained
      while (pending_count != 0) @(posedge clock);

      // random vectors, with a stretch of full rate on both sides
      for (int n = 0; n < NumRandom; n++) begin
         steady_sink = (n >= 600 && n < 800);
         x = pick_coord();
         y = pick_coord();
         z = pick_coord();
         send_vector(x, y, z, steady_sink);
      end
      steady_sink = 1'b0;
      req_bus.valid <= 1'b0;
      @(posedge clock);

      while (pending_count != 0) @(posedge clock);
      repeat (80) @(posedge clock);

      $display("Converted %0d vectors (directed axes, extremes, zero vector and random),",
               sent_count);
      $display("checked %0d results under random stalls on both channels.", result_count);
      if (fail_count == 0 && pending_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule

@@ filelist.f @@
+incdir+design
design/c2s_pkg.sv
design/c2s_req_if.sv
design/c2s_rsp_if.sv
design/cartesian_to_spherical.sv
dv/c2s_checker.sv
dv/tb.sv
